[rtl/hmpq_pkg.sv]
// Shared types and constants for the binary min-heap priority queue.
// Depends on nothing; binary_min_heap_priority_queue.sv imports it.
package hmpq_pkg;

    // Heap capacity and the widths that follow from it.
    localparam int CAPACITY = 1024;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = ADDR_W + 2;

    // Fixed field widths of the beats.
    localparam int KEY_W      = 31;
    localparam int PAY_W      = 16;
    localparam int COUNT_OUT_W = 11;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] pa;
        logic [PAY_W-1:0] pb;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic             cmd;
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload_a;
        logic [PAY_W-1:0] payload_b;
    } req_t;

    typedef struct packed {
        logic [KEY_W-1:0]       out_key;
        logic [PAY_W-1:0]       out_payload_a;
        logic [PAY_W-1:0]       out_payload_b;
        status_t                status;
        logic [COUNT_OUT_W-1:0] entry_count;
    } rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_POP_ROOT,
        S_POP_LAST,
        S_DN_RDL,
        S_DN_RDR,
        S_DN_CMP,
        S_UP_RD,
        S_UP_CMP,
        S_RESP
    } state_t;

endpackage

[rtl/hmpq_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
// Stands alone; uses no package.
module hmpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/binary_min_heap_priority_queue.sv]
// Top level of the binary min-heap priority queue: control FSM and heap memory.
// Depends on hmpq_pkg and hmpq_ram.
//
//   channel | beat type       | valid / stall         | carries
//   --------+-----------------+-----------------------+----------------------------------
//   req     | hmpq_pkg::req_t | req_valid / req_stall | push or pop command and new entry
//   rsp     | hmpq_pkg::rsp_t | rsp_valid / rsp_stall | popped entry, status, entry count
//
// A push moves its entry up at most log2(CAPACITY) levels. A pop moves the last entry
// to the root and sinks it, at most 9 levels at 1024 entries. Both are paced by the
// single read port of the heap memory and its registered read.
// Reset clears the entry count and the control state; the heap memory is not cleared,
// since only entries below the count are ever read. No clearing pass is needed.
// One command is processed at a time. req_stall is high while a command is in work, and a
// finished beat waits in the output register while the next command is accepted.
module binary_min_heap_priority_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  hmpq_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output hmpq_pkg::rsp_t rsp
);

    import hmpq_pkg::*;

    // Control state. The moving entry lives in cur_reg while the heap holds a hole at
    // pos_reg; each level writes one entry, so a swap never needs two writes.
    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [ADDR_W-1:0] pos_reg, pos_next;
    entry_t            cur_reg, cur_next;
    entry_t            left_reg, left_next;
    logic              has_right_reg, has_right_next;
    entry_t            res_entry_reg, res_entry_next;
    status_t           res_status_reg, res_status_next;
    rsp_t              rsp_reg, rsp_next;
    logic              rsp_valid_reg, rsp_valid_next;

    // Heap memory port signals.
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    entry_t            ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    entry_t            ram_rdata;

    // Index arithmetic. Child indexes carry two extra bits so that they compare
    // against the count without wrapping.
    logic [IDX_W-1:0]  fill_ext;
    logic [IDX_W-1:0]  left_idx;
    logic [IDX_W-1:0]  right_idx;
    logic [ADDR_W-1:0] pick_idx;
    entry_t            pick_entry;
    logic [IDX_W-1:0]  next_left_idx;
    logic [ADDR_W-1:0] parent_idx;
    logic [ADDR_W-1:0] grand_idx;
    logic              heap_full;
    logic              req_take;
    logic              rsp_take;

    assign fill_ext   = IDX_W'(fill_reg);
    assign left_idx   = {1'b0, pos_reg, 1'b1};
    assign right_idx  = left_idx + IDX_W'(1);
    assign parent_idx = (pos_reg - ADDR_W'(1)) >> 1;
    assign grand_idx  = (parent_idx - ADDR_W'(1)) >> 1;
    assign heap_full  = (fill_reg == CNT_W'(CAPACITY));

    // On a key tie between the children the left one is taken.
    always_comb
    begin
        if (has_right_reg && (left_reg.key > ram_rdata.key))
        begin
            pick_idx   = right_idx[ADDR_W-1:0];
            pick_entry = ram_rdata;
        end
        else
        begin
            pick_idx   = left_idx[ADDR_W-1:0];
            pick_entry = left_reg;
        end
    end

    assign next_left_idx = {1'b0, pick_idx, 1'b1};

    assign req_stall = (state_reg != S_IDLE);
    assign req_take  = req_valid && !req_stall;
    assign rsp_take  = rsp_valid_reg && !rsp_stall;

    hmpq_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(CAPACITY)
    ) u_heap_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg        <= pos_next;
        cur_reg        <= cur_next;
        left_reg       <= left_next;
        has_right_reg  <= has_right_next;
        res_entry_reg  <= res_entry_next;
        res_status_reg <= res_status_next;
        rsp_reg        <= rsp_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        pos_next        = pos_reg;
        cur_next        = cur_reg;
        left_next       = left_reg;
        has_right_next  = has_right_reg;
        res_entry_next  = res_entry_reg;
        res_status_next = res_status_reg;
        rsp_next        = rsp_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp_take;
        ram_we          = 1'b0;
        ram_waddr       = pos_reg;
        ram_wdata       = cur_reg;
        ram_re          = 1'b0;
        ram_raddr       = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_take)
                begin
                    res_entry_next  = '0;
                    res_status_next = ST_OK;
                    if (req.cmd == CMD_PUSH)
                    begin
                        if (heap_full)
                        begin
                            res_status_next = ST_FULL;
                            state_next      = S_RESP;
                        end
                        else
                        begin
                            cur_next.key = req.key;
                            cur_next.pa  = req.payload_a;
                            cur_next.pb  = req.payload_b;
                            pos_next     = fill_reg[ADDR_W-1:0];
                            fill_next    = fill_reg + CNT_W'(1);
                            state_next   = S_UP_RD;
                        end
                    end
                    else
                    begin
                        if (fill_reg == '0)
                        begin
                            res_status_next = ST_EMPTY;
                            state_next      = S_RESP;
                        end
                        else
                        begin
                            ram_re     = 1'b1;
                            ram_raddr  = '0;
                            fill_next  = fill_reg - CNT_W'(1);
                            state_next = S_POP_ROOT;
                        end
                    end
                end
            end

            S_POP_ROOT:
            begin
                // The root is the result; the last entry moves to the root.
                res_entry_next = ram_rdata;
                if (fill_reg == '0)
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = fill_reg[ADDR_W-1:0];
                    state_next = S_POP_LAST;
                end
            end

            S_POP_LAST:
            begin
                cur_next   = ram_rdata;
                pos_next   = '0;
                state_next = S_DN_RDL;
            end

            S_DN_RDL:
            begin
                if (left_idx >= fill_ext)
                begin
                    ram_we     = 1'b1;
                    state_next = S_RESP;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = left_idx[ADDR_W-1:0];
                    state_next = S_DN_RDR;
                end
            end

            S_DN_RDR:
            begin
                left_next = ram_rdata;
                if (right_idx < fill_ext)
                begin
                    ram_re         = 1'b1;
                    ram_raddr      = right_idx[ADDR_W-1:0];
                    has_right_next = 1'b1;
                end
                else
                begin
                    has_right_next = 1'b0;
                end
                state_next = S_DN_CMP;
            end

            S_DN_CMP:
            begin
                ram_we = 1'b1;
                if (cur_reg.key > pick_entry.key)
                begin
                    // The smaller child moves up into the hole; the next left child
                    // read goes out in the same cycle when that child exists.
                    ram_wdata = pick_entry;
                    pos_next  = pick_idx;
                    if (next_left_idx < fill_ext)
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = next_left_idx[ADDR_W-1:0];
                        state_next = S_DN_RDR;
                    end
                    else
                    begin
                        state_next = S_DN_RDL;
                    end
                end
                else
                begin
                    state_next = S_RESP;
                end
            end

            S_UP_RD:
            begin
                if (pos_reg == '0)
                begin
                    ram_we     = 1'b1;
                    state_next = S_RESP;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = parent_idx;
                    state_next = S_UP_CMP;
                end
            end

            S_UP_CMP:
            begin
                ram_we = 1'b1;
                if (ram_rdata.key > cur_reg.key)
                begin
                    // The parent moves down into the hole and, unless it was the root, the grandparent is fetched.
                    ram_wdata = ram_rdata;
                    pos_next  = parent_idx;
                    if (parent_idx != '0)
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = grand_idx;
                    end
                    else
                    begin
                        state_next = S_UP_RD;
                    end
                end
                else
                begin
                    state_next = S_RESP;
                end
            end

            S_RESP:
            begin
                if (!rsp_valid_reg || rsp_take)
                begin
                    rsp_next.out_key       = res_entry_reg.key;
                    rsp_next.out_payload_a = res_entry_reg.pa;
                    rsp_next.out_payload_b = res_entry_reg.pb;
                    rsp_next.status        = res_status_reg;
                    rsp_next.entry_count   = COUNT_OUT_W'(fill_reg);
                    rsp_valid_next         = 1'b1;
                    state_next             = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // The count never passes the capacity.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(CAPACITY))
        else $error("heap count exceeds capacity");

    // The heap memory is only written while a command is in work.
    a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !ram_we)
        else $error("heap write while idle");

    // A read never targets the entry written in the same cycle.
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("read and write to the same heap entry");

    // A push that finds room grows the count by one.
    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        (req_take && (req.cmd == CMD_PUSH) && !heap_full)
            |=> (fill_reg == $past(fill_reg) + CNT_W'(1)))
        else $error("push did not grow the count");

    // A new output beat only appears out of the response state.
    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> ($past(state_reg) == S_RESP))
        else $error("output beat raised outside the response state");

endmodule

[sim/tb_binary_min_heap_priority_queue.sv]
`timescale 1ns / 1ps
// Self-checking testbench for binary_min_heap_priority_queue: random push and pop beats
// are checked against a heap model kept here. Depends on hmpq_pkg and the block itself.
module tb_binary_min_heap_priority_queue;
    import hmpq_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 3;
    // Cycles with no beat on either channel before the run is declared hung. The slowest
    // legal stretch is the longest request gap, the slowest pop and the longest response
    // stall, so this is far beyond anything a working block needs.
    localparam int HANG_LIMIT   = 4000;
    // Quiet cycles after the last response, longer than the slowest pop.
    localparam int TAIL_CYCLES  = 40;
    localparam int MIXED_ITEMS  = 60;
    // Pops taken from the full heap at the end; each one sinks its entry deep.
    localparam int DRAIN_ITEMS  = 100;

    localparam logic [KEY_W-1:0] KEY_MAX = '1;
    localparam logic [PAY_W-1:0] PAY_MAX = '1;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    binary_min_heap_priority_queue dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // Commands waiting to be driven, and the response beats the heap model has predicted
    // for commands already accepted by the block, oldest first.
    req_t cmd_queue [$];
    rsp_t pending_rsp [$];

    // Heap model: same layout as the block, root at 0, children of i at 2i+1 and 2i+2.
    entry_t      heap_model [CAPACITY];
    int unsigned heap_fill   = 0;
    // Entry count as the stimulus builder expects it, used only to shape the command mix.
    int unsigned plan_fill   = 0;

    int unsigned error_count = 0;
    int unsigned req_idle    = 0;
    int unsigned req_calm    = 0;
    int unsigned rsp_hold    = 0;
    int unsigned rsp_calm    = 0;
    int unsigned hang_cycles = 0;

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    // ------------------------------------------------------------------------------------
    // Heap model
    // ------------------------------------------------------------------------------------

    function automatic void swap_entries(int unsigned a, int unsigned b);
        entry_t t;
        t             = heap_model[a];
        heap_model[a] = heap_model[b];
        heap_model[b] = t;
    endfunction

    // Applies one command to the heap model and returns the response beat it must cause.
    // A push sifts up only while the parent key is strictly greater, so equal keys keep
    // their arrival order along a path. A pop moves the last entry to the root and sifts
    // it down, taking the left child when the two children tie.
    function automatic rsp_t heap_apply(req_t c);
        rsp_t        r;
        int unsigned pos;
        int unsigned up;
        int unsigned pick;
        bit          moving;
        r        = '0;
        r.status = ST_OK;
        if (c.cmd == CMD_PUSH)
        begin
            if (heap_fill >= CAPACITY)
            begin
                r.status = ST_FULL;
            end
            else
            begin
                pos                 = heap_fill;
                heap_model[pos].key = c.key;
                heap_model[pos].pa  = c.payload_a;
                heap_model[pos].pb  = c.payload_b;
                heap_fill++;
                moving = 1'b1;
                while (moving && pos > 0)
                begin
                    up = (pos - 1) / 2;
                    if (heap_model[up].key > heap_model[pos].key)
                    begin
                        swap_entries(up, pos);
                        pos = up;
                    end
                    else
                    begin
                        moving = 1'b0;
                    end
                end
            end
        end
        else if (heap_fill == 0)
        begin
            r.status = ST_EMPTY;
        end
        else
        begin
            r.out_key       = heap_model[0].key;
            r.out_payload_a = heap_model[0].pa;
            r.out_payload_b = heap_model[0].pb;
            heap_fill--;
            heap_model[0] = heap_model[heap_fill];
            pos    = 0;
            moving = 1'b1;
            while (moving && 2 * pos + 1 < heap_fill)
            begin
                pick = 2 * pos + 1;
                if (pick + 1 < heap_fill && heap_model[pick].key > heap_model[pick + 1].key)
                begin
                    pick = pick + 1;
                end
                if (heap_model[pos].key > heap_model[pick].key)
                begin
                    swap_entries(pos, pick);
                    pos = pick;
                end
                else
                begin
                    moving = 1'b0;
                end
            end
        end
        r.entry_count = COUNT_OUT_W'(heap_fill);
        return r;
    endfunction

    // ------------------------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------------------------

    function automatic void plan_push(logic [KEY_W-1:0] k, logic [PAY_W-1:0] a,
                                      logic [PAY_W-1:0] b);
        req_t c;
        c.cmd       = CMD_PUSH;
        c.key       = k;
        c.payload_a = a;
        c.payload_b = b;
        cmd_queue.insert(cmd_queue.size(), c);
        if (plan_fill < CAPACITY)
        begin
            plan_fill++;
        end
    endfunction

    // The key and payload fields of a pop are ignored, so they carry random bits.
    function automatic void plan_pop();
        req_t c;
        c.cmd       = CMD_POP;
        c.key       = KEY_W'($urandom);
        c.payload_a = PAY_W'($urandom);
        c.payload_b = PAY_W'($urandom);
        cmd_queue.insert(cmd_queue.size(), c);
        if (plan_fill > 0)
        begin
            plan_fill--;
        end
    endfunction

    // Small key ranges give many ties, which is where the sift rules matter most.
    function automatic logic [KEY_W-1:0] random_key();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 4)
        begin
            return KEY_W'($urandom_range(0, 15));
        end
        if (r < 6)
        begin
            return KEY_W'($urandom_range(0, 255));
        end
        return KEY_W'($urandom);
    endfunction

    function automatic void plan_random_push();
        plan_push(random_key(), PAY_W'($urandom), PAY_W'($urandom));
    endfunction

    // Idle length for either side: mostly none or short, now and then long, and inside a
    // calm stretch none at all.
    function automatic int unsigned next_gap(inout int unsigned calm);
        int unsigned r;
        if (calm != 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 49) == 0)
        begin
            calm = $urandom_range(20, 60);
        end
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------------------------
    // Request driver: one beat at a time from cmd_queue, held while stalled. Each beat is
    // passed to the heap model at the edge where the block accepts it.
    // ------------------------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
            req_idle  <= 0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                pending_rsp.insert(pending_rsp.size(), heap_apply(req));
            end
            if (!req_valid || !req_stall)
            begin
                if (req_idle != 0)
                begin
                    req_valid <= 1'b0;
                    req_idle  <= req_idle - 1;
                end
                else if (cmd_queue.size() != 0)
                begin
                    req       <= cmd_queue[0];
                    cmd_queue.delete(0);
                    req_valid <= 1'b1;
                    req_idle  <= next_gap(req_calm);
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------------------
    // Response monitor: stalls at random and checks every accepted beat field by field
    // against the oldest prediction.
    // ------------------------------------------------------------------------------------

    task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : rsp_monitor
        rsp_t        want;
        int unsigned hold;
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            rsp_hold  <= 0;
        end
        else
        begin
            hold = rsp_hold;
            if (rsp_valid && !rsp_stall)
            begin
                if (pending_rsp.size() == 0)
                begin
                    $display("%0t: unexpected response beat, expected none, actual %h",
                             $time, rsp);
                    error_count++;
                end
                else
                begin
                    want = pending_rsp[0];
                    pending_rsp.delete(0);
                    check_field("out_key", 32'(want.out_key), 32'(rsp.out_key));
                    check_field("out_payload_a", 32'(want.out_payload_a),
                                32'(rsp.out_payload_a));
                    check_field("out_payload_b", 32'(want.out_payload_b),
                                32'(rsp.out_payload_b));
                    check_field("status", 32'(want.status), 32'(rsp.status));
                    check_field("entry_count", 32'(want.entry_count), 32'(rsp.entry_count));
                end
                hold = next_gap(rsp_calm);
            end
            else if (hold == 0 && rsp_calm == 0 && $urandom_range(0, 19) == 0)
            begin
                // Occasional stall that does not follow a beat, so stalls also land while
                // the block is still working on a command.
                hold = $urandom_range(1, 6);
            end
            if (hold != 0)
            begin
                rsp_stall <= 1'b1;
                rsp_hold  <= hold - 1;
            end
            else
            begin
                rsp_stall <= 1'b0;
                rsp_hold  <= 0;
            end
        end
    end

    // Watchdog: ends the run if neither channel moves a beat for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            begin
                hang_cycles = 0;
            end
            else
            begin
                hang_cycles++;
            end
            if (hang_cycles >= HANG_LIMIT)
            begin
                $display("[binary_min_heap_priority_queue] ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------------------

    initial
    begin : main_seq
        int unsigned mixed;
        int unsigned burst;
        bit          pushing;

        // Directed part. A pop on the empty heap first, then the extreme keys and payloads,
        // a run of equal keys so that both the no-swap-on-equal rule on the way up and the
        // left-child-on-tie rule on the way down are exercised, then a full drain and one
        // more pop on the empty heap.
        plan_pop();
        plan_push(KEY_MAX, PAY_MAX, PAY_MAX);
        plan_push('0, '0, '0);
        plan_push(KEY_W'(5), 16'h0001, 16'h0002);
        plan_push(KEY_W'(5), 16'h0003, 16'h0004);
        plan_push(KEY_W'(5), 16'hAAAA, 16'h5555);
        plan_push(KEY_W'(5), 16'h5555, 16'hAAAA);
        plan_push(31'h2AAA_AAAA, 16'h00FF, 16'hFF00);
        plan_push(31'h5555_5555, 16'hFF00, 16'h00FF);
        plan_push(31'h4000_0000, 16'h8000, 16'h0001);
        repeat (10)
        begin
            plan_pop();
        end

        // Mixed part: bursts of pushes or pops with a few of the other kind inside,
        // leaning toward pushes while the heap is nearly empty so that it grows deep.
        mixed = 0;
        while (mixed < MIXED_ITEMS)
        begin
            burst   = $urandom_range(1, 16);
            pushing = ($urandom_range(0, 99) < (plan_fill < 4 ? 80 : 58));
            repeat (burst)
            begin
                if (pushing ^ ($urandom_range(0, 99) < 15))
                begin
                    plan_random_push();
                end
                else
                begin
                    plan_pop();
                end
                mixed++;
            end
        end

        // Fill the heap to capacity, push into the full heap, churn near the top, push into it
        // once more and then pop from the full heap so that the deepest sift-downs are seen.
        while (plan_fill < CAPACITY)
        begin
            plan_random_push();
        end
        repeat (4)
        begin
            plan_random_push();
        end
        repeat (20)
        begin
            plan_pop();
            plan_random_push();
        end
        plan_random_push();
        repeat (DRAIN_ITEMS)
        begin
            plan_pop();
        end

        // Reset is held at the start and released at a clock edge.
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Sampled on the falling edge, clear of the updates made at the rising edge.
        @(negedge clk);
        while (cmd_queue.size() != 0 || req_valid || pending_rsp.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        if (error_count == 0)
        begin
            $display("[binary_min_heap_priority_queue] OK");
        end
        else
        begin
            $display("[binary_min_heap_priority_queue] ERROR");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/hmpq_pkg.sv
rtl/hmpq_ram.sv
rtl/binary_min_heap_priority_queue.sv
sim/tb_binary_min_heap_priority_queue.sv
